/* design/pctb_pkg.sv */
// Package with the command codes and transfer payload types of the countdown timer bank.
package pctb_pkg;

  localparam int CMD_W   = 2;
  localparam int INDEX_W = 4;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 33;
  localparam int TICKS_W = 64;

  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [INDEX_W-1:0] timer_index;
    logic [VALUE_W-1:0] count_value;
  } in_item_t;

  typedef struct packed {
    logic               timer_done;
    logic [COUNT_W-1:0] ticks_remaining;
    logic [TICKS_W-1:0] tick_count;
  } out_item_t;

endpackage

/* design/polled_countdown_timer_bank.sv */
// Top level of the countdown timer bank: sequencer, shared decrementer and count RAM.
// A query passes through a RAM read state and an output state to its result strobe; a restart writes the RAM first.
// A tick walks the count RAM with one shared decrementer, one timer
// per cycle, with the RAM read of the next timer overlapping the write-back of the current one.
// busy is low again in the strobe cycle, so the next command can be accepted there.
// Synchronous active-low reset marks every timer done with a zero count and clears the ticks.
module polled_countdown_timer_bank #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pctb_pkg::in_item_t  in_item,
  output logic                out_valid,
  output pctb_pkg::out_item_t out_item
);
  import pctb_pkg::*;

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TIMERS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TICK  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [INDEX_W-1:0]    idx_r;
  logic [VALUE_W-1:0]    val_r;
  logic [AW-1:0]         cnt_r, cnt_nxt;
  logic                  p_vld_r, p_vld_nxt;
  logic [AW-1:0]         p_idx_r;
  logic [NUM_TIMERS-1:0] done_r, done_nxt;
  logic [NUM_TIMERS-1:0] wrt_r, wrt_nxt;
  logic [TICKS_W-1:0]    ticks_r, ticks_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;

  logic                  accept;
  logic                  idx_ok;
  logic [IW-1:0]         idx_ext;
  logic [AW-1:0]         addr_idx;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_W-1:0]    ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [COUNT_W-1:0]    ram_rdata;
  logic [COUNT_W-1:0]    cur_count;
  logic [COUNT_W-1:0]    dec_count;
  logic                  dec_en;

  assign accept   = start && (state_r == S_IDLE);
  assign idx_ext  = IW'(idx_r);
  assign addr_idx = idx_ext[AW-1:0];
  assign idx_ok   = (32'(idx_r) < NUM_TIMERS);

  // Shared decrementer on the count read back from the RAM; unwritten entries read as zero.
  assign cur_count = wrt_r[p_idx_r] ? ram_rdata : '0;
  assign dec_count = cur_count - COUNT_W'(1);
  assign dec_en    = p_vld_r && !done_r[p_idx_r];

  // RAM port selection by sequencer state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_idx;
    ram_wdata = COUNT_W'(val_r) + COUNT_W'(1);
    ram_raddr = addr_idx;
    if (state_r == S_TICK) begin
      ram_raddr = cnt_r;
    end
    if (dec_en) begin
      ram_we    = 1'b1;
      ram_waddr = p_idx_r;
      ram_wdata = dec_count;
    end else if ((state_r == S_WR) && idx_ok) begin
      ram_we = 1'b1;
    end
  end

  pctb_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer and flag updates.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    p_vld_nxt     = 1'b0;
    done_nxt      = done_r;
    wrt_nxt       = wrt_r;
    ticks_nxt     = ticks_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    if (dec_en) begin
      wrt_nxt[p_idx_r] = 1'b1;
      if (dec_count == '0) begin
        done_nxt[p_idx_r] = 1'b1;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          if (in_item.command == CMD_TICK) begin
            state_nxt = S_TICK;
          end else if (in_item.command == CMD_RESTART) begin
            state_nxt = S_WR;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_TICK: begin
        p_vld_nxt = 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_DRAIN: begin
        ticks_nxt = ticks_r + TICKS_W'(1);
        state_nxt = S_RD;
      end
      S_WR: begin
        if (idx_ok) begin
          wrt_nxt[addr_idx]  = 1'b1;
          done_nxt[addr_idx] = (val_r == '0);
        end
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt      = 1'b1;
        out_nxt.tick_count = ticks_r;
        if (idx_ok) begin
          out_nxt.timer_done      = done_r[addr_idx];
          out_nxt.ticks_remaining = wrt_r[addr_idx] ? ram_rdata : '0;
        end else begin
          out_nxt.timer_done      = 1'b1;
          out_nxt.ticks_remaining = '0;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      p_vld_r     <= 1'b0;
      done_r      <= '1;
      wrt_r       <= '0;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_vld_r     <= p_vld_nxt;
      done_r      <= done_nxt;
      wrt_r       <= wrt_nxt;
      ticks_r     <= ticks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: command capture, walk pointers and result.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= in_item.timer_index;
      val_r <= in_item.count_value;
    end
    cnt_r   <= cnt_nxt;
    p_idx_r <= cnt_r;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

/* design/pctb_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module pctb_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/pctb_checker.sv */
// Port-level checker for the countdown timer bank, bound to the top level.
module pctb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input pctb_pkg::out_item_t out_item
);
  import pctb_pkg::*;

  // An accepted command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted command");

  // The block only becomes busy through an accepted command.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  // A result strobe lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // A result is delivered only once the command has finished.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // A running timer always reports a nonzero remaining count.
  a_running_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.timer_done) |-> (out_item.ticks_remaining != '0))
    else $error("running timer reported with zero count");

endmodule

bind polled_countdown_timer_bank pctb_checker u_pctb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
